// ===== rtl/core/xsv_pkg.sv =====
// Shared types and constants of the xor sprite bytecode core.
// Holds the sequencer state type, item and opcode codes, and the font glyph table.
// No dependencies.
package xsv_pkg;

    localparam int MEM_AW     = 12;
    localparam int FRM_ROWS   = 32;
    localparam int FRM_COLS   = 64;
    localparam int FONT_BYTES = 80;
    localparam int REG_NUM    = 16;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_EXEC  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEI  = 4'h3;
    localparam logic [3:0] OP_SNEI = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDI  = 4'h6;
    localparam logic [3:0] OP_ADDI = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDIX = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_DRW  = 4'hD;

    localparam logic [15:0] INSTR_CLS = 16'h00E0;
    localparam logic [15:0] INSTR_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [3:0] REG_FLAG = 4'hF;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PIX,
        S_F1,
        S_F2,
        S_RX,
        S_RY,
        S_EX,
        S_WF,
        S_CLS,
        S_DR,
        S_DM,
        S_DW,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [7:0] result;
        logic       flag;
        logic       flag_we;
        logic       unk;
    } alu_res_t;

    function automatic logic [7:0] font_byte(input logic [6:0] idx);
        logic [7:0] b;
        case (idx)
            7'd0:  b = 8'hF0; 7'd1:  b = 8'h90; 7'd2:  b = 8'h90; 7'd3:  b = 8'h90;
            7'd4:  b = 8'hF0; 7'd5:  b = 8'h20; 7'd6:  b = 8'h60; 7'd7:  b = 8'h20;
            7'd8:  b = 8'h20; 7'd9:  b = 8'h70; 7'd10: b = 8'hF0; 7'd11: b = 8'h10;
            7'd12: b = 8'hF0; 7'd13: b = 8'h80; 7'd14: b = 8'hF0; 7'd15: b = 8'hF0;
            7'd16: b = 8'h10; 7'd17: b = 8'hF0; 7'd18: b = 8'h10; 7'd19: b = 8'hF0;
            7'd20: b = 8'h90; 7'd21: b = 8'h90; 7'd22: b = 8'hF0; 7'd23: b = 8'h10;
            7'd24: b = 8'h10; 7'd25: b = 8'hF0; 7'd26: b = 8'h80; 7'd27: b = 8'hF0;
            7'd28: b = 8'h10; 7'd29: b = 8'hF0; 7'd30: b = 8'hF0; 7'd31: b = 8'h80;
            7'd32: b = 8'hF0; 7'd33: b = 8'h90; 7'd34: b = 8'hF0; 7'd35: b = 8'hF0;
            7'd36: b = 8'h10; 7'd37: b = 8'h20; 7'd38: b = 8'h40; 7'd39: b = 8'h40;
            7'd40: b = 8'hF0; 7'd41: b = 8'h90; 7'd42: b = 8'hF0; 7'd43: b = 8'h90;
            7'd44: b = 8'hF0; 7'd45: b = 8'hF0; 7'd46: b = 8'h90; 7'd47: b = 8'hF0;
            7'd48: b = 8'h10; 7'd49: b = 8'hF0; 7'd50: b = 8'hF0; 7'd51: b = 8'h90;
            7'd52: b = 8'hF0; 7'd53: b = 8'h90; 7'd54: b = 8'h90; 7'd55: b = 8'hE0;
            7'd56: b = 8'h90; 7'd57: b = 8'hE0; 7'd58: b = 8'h90; 7'd59: b = 8'hE0;
            7'd60: b = 8'hF0; 7'd61: b = 8'h80; 7'd62: b = 8'h80; 7'd63: b = 8'h80;
            7'd64: b = 8'hF0; 7'd65: b = 8'hE0; 7'd66: b = 8'h90; 7'd67: b = 8'h90;
            7'd68: b = 8'h90; 7'd69: b = 8'hE0; 7'd70: b = 8'hF0; 7'd71: b = 8'h80;
            7'd72: b = 8'hF0; 7'd73: b = 8'h80; 7'd74: b = 8'hF0; 7'd75: b = 8'hF0;
            7'd76: b = 8'h80; 7'd77: b = 8'hF0; 7'd78: b = 8'h80; 7'd79: b = 8'h80;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/xsv_if.sv =====
// Valid/ready channel interfaces for the request and response sides of the core.
// No dependencies.
interface xsv_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [11:0] addr;
    logic [7:0]  data;

    modport source(output valid, func, addr, data, input ready);
    modport sink(input valid, func, addr, data, output ready);
endinterface

interface xsv_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [11:0] prog_counter;
    logic [15:0] instr_word;
    logic        status;
    logic        drew;
    logic [7:0]  flag_reg;

    modport source(output valid, read_data, prog_counter, instr_word, status, drew, flag_reg,
                   input ready);
    modport sink(input valid, read_data, prog_counter, instr_word, status, drew, flag_reg,
                 output ready);
endinterface

// ===== rtl/core/xsv_alu.sv =====
// Register-register ALU of the 8XY instruction group with flag result.
// Depends on xsv_pkg.
module xsv_alu
    import xsv_pkg::*;
(
    input  logic [7:0] vx,
    input  logic [7:0] vy,
    input  logic [3:0] fn,
    output alu_res_t   res
);

    logic [8:0] sum;

    assign sum = {1'b0, vx} + {1'b0, vy};

    always_comb
    begin
        res = '0;
        unique case (fn)
            ALU_MOV: res.result = vy;
            ALU_OR:  res.result = vx | vy;
            ALU_AND: res.result = vx & vy;
            ALU_XOR: res.result = vx ^ vy;
            ALU_ADD:
            begin
                res.result  = sum[7:0];
                res.flag    = sum[8];
                res.flag_we = 1'b1;
            end
            ALU_SUB:
            begin
                res.result  = vx - vy;
                res.flag    = (vx >= vy);
                res.flag_we = 1'b1;
            end
            ALU_SHR:
            begin
                res.result  = {1'b0, vx[7:1]};
                res.flag    = vx[0];
                res.flag_we = 1'b1;
            end
            ALU_SBN:
            begin
                res.result  = vy - vx;
                res.flag    = (vy >= vx);
                res.flag_we = 1'b1;
            end
            ALU_SHL:
            begin
                res.result  = {vx[6:0], 1'b0};
                res.flag    = vx[7];
                res.flag_we = 1'b1;
            end
            default: res.unk = 1'b1;
        endcase
    end

endmodule

// ===== rtl/core/xor_sprite_vm_core.sv =====
// Top level of the xor sprite bytecode core: sequencer, memories, registers.
// Depends on xsv_pkg, xsv_if and xsv_alu.
//
// Usage: requests arrive on req (func, addr, data), one response per request
// leaves on rsp. A request transfers when req.valid and req.ready are high.
// func 0 writes a program byte, func 1 executes one instruction at the
// program counter, func 2 reads one display pixel, func 3 does nothing.
// A write or func 3 answers straight from the response register; a pixel read
// first reads the display row; a plain instruction makes two fetch reads and two
// register reads through the single register file port; CLS clears each display
// row in turn; a sprite draw makes a memory read, display row read and row write per row.
// One request is in flight at a time; req.ready is low while it executes and
// while a response waits, so a stalled rsp.ready holds the response register
// and blocks the next request.
// After reset the core sweeps all 4096 program memory addresses, loading the font
// and zeroing the rest, the registers and the display, with req.ready low.
module xor_sprite_vm_core
    import xsv_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int START_ADDR  = 512
)
(
    input  logic         clk,
    input  logic         rst_n,
    xsv_req_if.sink      req,
    xsv_rsp_if.source    rsp
);

    localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    state_t state_reg, state_next;

    logic [11:0]     clr_cnt_reg, clr_cnt_next;
    logic [11:0]     pc_reg, pc_next;
    logic [11:0]     index_reg, index_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [11:0]     stack_reg [STACK_DEPTH];
    logic            stack_we;
    logic [15:0]     ir_reg, ir_next;
    logic [7:0]      vx_reg, vx_next;
    logic [4:0]      py_reg, py_next;
    logic [7:0]      spr_reg, spr_next;
    logic [3:0]      row_reg, row_next;
    logic            coll_reg, coll_next;
    logic            unk_reg, unk_next;
    logic            drw_reg, drw_next;
    logic [7:0]      vf_reg, vf_next;
    logic [7:0]      fh_reg, fh_next;
    logic [11:0]     addr_reg, addr_next;

    logic            res_valid_reg, res_valid_next;
    logic [7:0]      res_rd_reg, res_rd_next;
    logic [11:0]     res_pc_reg, res_pc_next;
    logic [15:0]     res_word_reg, res_word_next;
    logic            res_st_reg, res_st_next;
    logic            res_drew_reg, res_drew_next;
    logic [7:0]      res_flag_reg, res_flag_next;

    logic [7:0]  mem [1 << MEM_AW];
    logic        mem_we;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_q;

    logic [7:0]  regs [REG_NUM];
    logic        reg_we;
    logic [3:0]  reg_waddr, reg_raddr;
    logic [7:0]  reg_wdata, reg_q;

    logic [FRM_COLS-1:0] frame [FRM_ROWS];
    logic                frm_we;
    logic [4:0]          frm_waddr, frm_raddr;
    logic [FRM_COLS-1:0] frm_wdata, frm_q;

    logic                  accept;
    logic [SP_W-1:0]       sp_dec, sp_inc;
    logic [7:0]            spr_rev;
    logic [FRM_COLS-1:0]   spr_wide;
    logic [2*FRM_COLS-1:0] rot_tmp;
    logic [FRM_COLS-1:0]   mask;
    alu_res_t              alu_res;
    logic [4:0]            draw_row;

    xsv_alu u_alu (
        .vx  (vx_reg),
        .vy  (reg_q),
        .fn  (ir_reg[3:0]),
        .res (alu_res)
    );

    assign req.ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign accept    = req.valid && req.ready;

    assign rsp.valid        = res_valid_reg;
    assign rsp.read_data    = res_rd_reg;
    assign rsp.prog_counter = res_pc_reg;
    assign rsp.instr_word   = res_word_reg;
    assign rsp.status       = res_st_reg;
    assign rsp.drew         = res_drew_reg;
    assign rsp.flag_reg     = res_flag_reg;

    assign sp_dec = (sp_reg == '0) ? SP_W'(STACK_DEPTH - 1) : sp_reg - SP_W'(1);
    assign sp_inc = (sp_reg == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_reg + SP_W'(1);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            spr_rev[i] = spr_reg[7 - i];
        end
    end

    assign spr_wide = {{(FRM_COLS - 8){1'b0}}, spr_rev};
    assign rot_tmp  = {spr_wide, spr_wide} << vx_reg[5:0];
    assign mask     = rot_tmp[2*FRM_COLS-1:FRM_COLS];
    assign draw_row = py_reg + {1'b0, row_reg};

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        pc_next        = pc_reg;
        index_next     = index_reg;
        sp_next        = sp_reg;
        stack_we       = 1'b0;
        ir_next        = ir_reg;
        vx_next        = vx_reg;
        py_next        = py_reg;
        spr_next       = spr_reg;
        row_next       = row_reg;
        coll_next      = coll_reg;
        unk_next       = unk_reg;
        drw_next       = drw_reg;
        fh_next        = fh_reg;
        addr_next      = addr_reg;
        res_valid_next = res_valid_reg;
        res_rd_next    = res_rd_reg;
        res_pc_next    = res_pc_reg;
        res_word_next  = res_word_reg;
        res_st_next    = res_st_reg;
        res_drew_next  = res_drew_reg;
        res_flag_next  = res_flag_reg;
        mem_we         = 1'b0;
        mem_waddr      = req.addr;
        mem_wdata      = req.data;
        mem_raddr      = pc_reg;
        reg_we         = 1'b0;
        reg_waddr      = ir_reg[11:8];
        reg_wdata      = 8'h00;
        reg_raddr      = ir_reg[11:8];
        frm_we         = 1'b0;
        frm_waddr      = draw_row;
        frm_wdata      = '0;
        frm_raddr      = draw_row;

        if (rsp.valid && rsp.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = (clr_cnt_reg < 12'(FONT_BYTES)) ? font_byte(clr_cnt_reg[6:0])
                                                             : 8'h00;
                reg_we    = (clr_cnt_reg < 12'(REG_NUM));
                reg_waddr = clr_cnt_reg[3:0];
                frm_we    = (clr_cnt_reg < 12'(FRM_ROWS));
                frm_waddr = clr_cnt_reg[4:0];
                clr_cnt_next = clr_cnt_reg + 12'd1;
                if (clr_cnt_reg == 12'hFFF)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    addr_next     = req.addr;
                    unk_next      = 1'b0;
                    drw_next      = 1'b0;
                    res_rd_next   = 8'h00;
                    res_pc_next   = pc_reg;
                    res_word_next = 16'h0000;
                    res_st_next   = 1'b0;
                    res_drew_next = 1'b0;
                    res_flag_next = vf_reg;
                    unique case (req.func)
                        FUNC_WRITE:
                        begin
                            mem_we         = 1'b1;
                            res_valid_next = 1'b1;
                        end
                        FUNC_EXEC:
                        begin
                            mem_raddr  = pc_reg;
                            state_next = S_F1;
                        end
                        FUNC_READ:
                        begin
                            frm_raddr  = req.addr[10:6];
                            state_next = S_PIX;
                        end
                        default: res_valid_next = 1'b1;
                    endcase
                end
            end
            S_PIX:
            begin
                res_rd_next    = addr_reg[11] ? 8'h00 : {7'b0, frm_q[addr_reg[5:0]]};
                res_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_F1:
            begin
                ir_next[15:8] = mem_q;
                mem_raddr     = pc_reg + 12'd1;
                state_next    = S_F2;
            end
            S_F2:
            begin
                ir_next[7:0] = mem_q;
                state_next   = S_RX;
            end
            S_RX:
            begin
                reg_raddr  = (ir_reg[15:12] == OP_JPV0) ? 4'h0 : ir_reg[11:8];
                state_next = S_RY;
            end
            S_RY:
            begin
                vx_next    = reg_q;
                reg_raddr  = ir_reg[7:4];
                state_next = S_EX;
            end
            S_EX:
            begin
                pc_next    = pc_reg + 12'd2;
                state_next = S_FIN;
                unique case (ir_reg[15:12])
                    OP_SYS:
                    begin
                        if (ir_reg == INSTR_CLS)
                        begin
                            clr_cnt_next = '0;
                            state_next   = S_CLS;
                        end
                        else if (ir_reg == INSTR_RET)
                        begin
                            sp_next = sp_dec;
                            pc_next = stack_reg[sp_dec] + 12'd2;
                        end
                        else
                        begin
                            unk_next = 1'b1;
                        end
                    end
                    OP_JP: pc_next = ir_reg[11:0];
                    OP_CALL:
                    begin
                        stack_we = 1'b1;
                        sp_next  = sp_inc;
                        pc_next  = ir_reg[11:0];
                    end
                    OP_SEI:
                    begin
                        if (vx_reg == ir_reg[7:0]) pc_next = pc_reg + 12'd4;
                    end
                    OP_SNEI:
                    begin
                        if (vx_reg != ir_reg[7:0]) pc_next = pc_reg + 12'd4;
                    end
                    OP_SER:
                    begin
                        if (vx_reg == reg_q) pc_next = pc_reg + 12'd4;
                    end
                    OP_SNER:
                    begin
                        if (vx_reg != reg_q) pc_next = pc_reg + 12'd4;
                    end
                    OP_LDI:
                    begin
                        reg_we    = 1'b1;
                        reg_wdata = ir_reg[7:0];
                    end
                    OP_ADDI:
                    begin
                        reg_we    = 1'b1;
                        reg_wdata = vx_reg + ir_reg[7:0];
                    end
                    OP_ALU:
                    begin
                        if (alu_res.unk)
                        begin
                            unk_next = 1'b1;
                        end
                        else
                        begin
                            reg_we    = 1'b1;
                            reg_wdata = alu_res.result;
                            if (alu_res.flag_we)
                            begin
                                fh_next    = {7'b0, alu_res.flag};
                                state_next = S_WF;
                            end
                        end
                    end
                    OP_LDIX: index_next = ir_reg[11:0];
                    OP_JPV0: pc_next = ir_reg[11:0] + {4'h0, vx_reg};
                    OP_DRW:
                    begin
                        py_next    = reg_q[4:0];
                        row_next   = '0;
                        coll_next  = 1'b0;
                        drw_next   = 1'b1;
                        state_next = S_DR;
                    end
                    default: unk_next = 1'b1;
                endcase
            end
            S_WF:
            begin
                reg_we     = 1'b1;
                reg_waddr  = REG_FLAG;
                reg_wdata  = fh_reg;
                state_next = S_FIN;
            end
            S_CLS:
            begin
                frm_we       = 1'b1;
                frm_waddr    = clr_cnt_reg[4:0];
                clr_cnt_next = clr_cnt_reg + 12'd1;
                if (clr_cnt_reg == 12'(FRM_ROWS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_DR:
            begin
                if (row_reg == ir_reg[3:0])
                begin
                    reg_we     = 1'b1;
                    reg_waddr  = REG_FLAG;
                    reg_wdata  = {7'b0, coll_reg};
                    state_next = S_FIN;
                end
                else
                begin
                    mem_raddr  = index_reg + {8'h00, row_reg};
                    state_next = S_DM;
                end
            end
            S_DM:
            begin
                spr_next   = mem_q;
                state_next = S_DW;
            end
            S_DW:
            begin
                coll_next  = coll_reg | (|(frm_q & mask));
                frm_we     = 1'b1;
                frm_wdata  = frm_q ^ mask;
                row_next   = row_reg + 4'd1;
                state_next = S_DR;
            end
            S_FIN:
            begin
                res_valid_next = 1'b1;
                res_pc_next    = pc_reg;
                res_word_next  = ir_reg;
                res_st_next    = unk_reg;
                res_drew_next  = drw_reg;
                res_flag_next  = vf_reg;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        vf_next = (reg_we && (reg_waddr == REG_FLAG)) ? reg_wdata : vf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            pc_reg        <= 12'(START_ADDR);
            index_reg     <= '0;
            sp_reg        <= '0;
            vf_reg        <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                stack_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pc_reg        <= pc_next;
            index_reg     <= index_next;
            sp_reg        <= sp_next;
            vf_reg        <= vf_next;
            res_valid_reg <= res_valid_next;
            if (stack_we)
            begin
                stack_reg[sp_reg] <= pc_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ir_reg       <= ir_next;
        vx_reg       <= vx_next;
        py_reg       <= py_next;
        spr_reg      <= spr_next;
        row_reg      <= row_next;
        coll_reg     <= coll_next;
        unk_reg      <= unk_next;
        drw_reg      <= drw_next;
        fh_reg       <= fh_next;
        addr_reg     <= addr_next;
        res_rd_reg   <= res_rd_next;
        res_pc_reg   <= res_pc_next;
        res_word_reg <= res_word_next;
        res_st_reg   <= res_st_next;
        res_drew_reg <= res_drew_next;
        res_flag_reg <= res_flag_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (reg_we)
        begin
            regs[reg_waddr] <= reg_wdata;
        end
        reg_q <= regs[reg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (frm_we)
        begin
            frame[frm_waddr] <= frm_wdata;
        end
        frm_q <= frame[frm_raddr];
    end

`ifndef SYNTHESIS
    a_accept_leads_on: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (res_valid_reg || (state_reg != S_IDLE)))
        else $error("accepted request produced neither response nor work");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !req.ready)
        else $error("request taken during memory sweep");

    a_draw_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DW) |-> (row_reg < ir_reg[3:0]))
        else $error("sprite row past height");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !rsp.ready) |=> (res_valid_reg && $stable(res_pc_reg)))
        else $error("stalled response changed");
`endif

endmodule
